@@ hw/rtl/signed_varint_encoder_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the signed varint encoder
// Shared concurrent assertion forms, clocked on clk and gated by arst_n.
// ----------------------------------------------------------------------------
`ifndef SIGNED_VARINT_ENCODER_TOP_DEFINES_SVH
`define SIGNED_VARINT_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication
`define SVENC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("svenc assertion failed");

// Next-cycle implication
`define SVENC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("svenc assertion failed");

`endif

@@ hw/rtl/svenc_pkg.sv @@
// ----------------------------------------------------------------------------
// Signed varint encoder package
// Widths, group constants and the load record passed to the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package svenc_pkg;

	localparam int VALUE_W    = 32;
	localparam int FIRST_BITS = 6;
	localparam int NEXT_BITS  = 7;
	localparam int MAX_BYTES  = 5;
	localparam int SR_W       = NEXT_BITS * MAX_BYTES;
	localparam int CNT_W      = $clog2(MAX_BYTES + 1);

	localparam logic [CNT_W-1:0] LEN_1 = CNT_W'(1);
	localparam logic [CNT_W-1:0] LEN_2 = CNT_W'(2);
	localparam logic [CNT_W-1:0] LEN_3 = CNT_W'(3);
	localparam logic [CNT_W-1:0] LEN_4 = CNT_W'(4);
	localparam logic [CNT_W-1:0] LEN_5 = CNT_W'(5);

	// One encode job: sign, byte count and magnitude aligned to the top group
	typedef struct packed {
		logic             neg;
		logic [CNT_W-1:0] len;
		logic [SR_W-1:0]  aligned;
	} load_t;

endpackage

`default_nettype wire

@@ hw/rtl/signed_varint_encoder_top.sv @@
// ----------------------------------------------------------------------------
// Signed varint encoder, top level
// Encodes a signed 32-bit integer as 1 to 5 sign-magnitude varint bytes,
// most significant group first.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    value[31:0] signed
//   out      out  out_valid / out_ready  code_byte[7:0], last_byte
//
// A value is taken on load (magnitude and byte count are formed there),
// then one byte per cycle is shifted out of a 35-bit group shift register.
// A value of N bytes keeps the input closed until its groups are all out; the
// next value is taken while the last byte still waits in the output register.
// Back-pressure on out_ready holds the shift register and the input.
// Reset clears the control state only; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_varint_encoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic signed [svenc_pkg::VALUE_W-1:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       code_byte,
	output logic             last_byte
);
	import svenc_pkg::*;

	logic               busy;
	logic               load;
	logic               neg;
	logic [VALUE_W-1:0] mag;
	logic [SR_W-1:0]    mag_ext;
	load_t              ld;

	assign in_ready = !busy;
	assign load     = in_valid && in_ready;

	// Take the magnitude; the most negative value stays as unsigned 2^31
	assign neg     = value[VALUE_W-1];
	assign mag     = neg ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
	assign mag_ext = SR_W'(mag);

	// Count groups and align the top group to the head of the shift register
	always_comb begin
		ld.neg = neg;
		if (mag_ext[SR_W-1:FIRST_BITS + 3*NEXT_BITS] != '0) begin
			ld.len = LEN_5;
		end else if (mag_ext[SR_W-1:FIRST_BITS + 2*NEXT_BITS] != '0) begin
			ld.len = LEN_4;
		end else if (mag_ext[SR_W-1:FIRST_BITS + NEXT_BITS] != '0) begin
			ld.len = LEN_3;
		end else if (mag_ext[SR_W-1:FIRST_BITS] != '0) begin
			ld.len = LEN_2;
		end else begin
			ld.len = LEN_1;
		end
		case (ld.len)
			LEN_1:   ld.aligned = mag_ext << (4*NEXT_BITS);
			LEN_2:   ld.aligned = mag_ext << (3*NEXT_BITS);
			LEN_3:   ld.aligned = mag_ext << (2*NEXT_BITS);
			LEN_4:   ld.aligned = mag_ext << NEXT_BITS;
			default: ld.aligned = mag_ext;
		endcase
	end

	svenc_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.ld        (ld),
		.busy      (busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.code_byte (code_byte),
		.last_byte (last_byte)
	);

endmodule

`default_nettype wire

@@ hw/rtl/svenc_serializer.sv @@
// ----------------------------------------------------------------------------
// Signed varint byte serializer
// Shifts the aligned magnitude out one group per cycle (6 bits first, then 7)
// into a free output register, adding the sign and continuation bits.
// ----------------------------------------------------------------------------
`default_nettype none

module svenc_serializer (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire svenc_pkg::load_t ld,
	output logic                 busy,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           code_byte,
	output logic                 last_byte
);
	import svenc_pkg::*;

	logic [SR_W-1:0]  sr_q;
	logic             neg_q;
	logic             first_q;
	logic [CNT_W-1:0] left_q;
	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             adv;
	logic             final_grp;
	logic [7:0]       next_byte;

	// Advance when groups remain and the output register is free
	assign adv       = (left_q != '0) && (!out_valid_q || out_ready);
	assign final_grp = (left_q == LEN_1);

	// Build the next byte from the top group of the shift register
	always_comb begin
		if (first_q) begin
			next_byte = {!final_grp, neg_q, sr_q[SR_W-2 -: FIRST_BITS]};
		end else begin
			next_byte = {!final_grp, sr_q[SR_W-1 -: NEXT_BITS]};
		end
	end

	// Control: group count, first flag, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				left_q  <= ld.len;
				first_q <= 1'b1;
			end else if (adv) begin
				left_q  <= left_q - LEN_1;
				first_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: shift register and output byte
	always_ff @(posedge clk) begin
		if (load) begin
			sr_q  <= ld.aligned;
			neg_q <= ld.neg;
		end else if (adv) begin
			sr_q <= {sr_q[SR_W-NEXT_BITS-1:0], {NEXT_BITS{1'b0}}};
		end
		if (adv) begin
			byte_q <= next_byte;
			last_q <= final_grp;
		end
	end

	assign busy      = (left_q != '0);
	assign out_valid = out_valid_q;
	assign code_byte = byte_q;
	assign last_byte = last_q;

endmodule

`default_nettype wire

@@ hw/rtl/svenc_checker.sv @@
// ----------------------------------------------------------------------------
// Signed varint encoder port checker
// Watches the top-level ports for framing and handshake consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_varint_encoder_top_defines.svh"

module svenc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] code_byte,
	input wire logic       last_byte
);

	// Continuation bit on every byte but the last
	`SVENC_ASSERT_IMP(a_more_bit, out_valid, code_byte[7] != last_byte)

	// A non-final byte on the output means the value is still being emitted
	`SVENC_ASSERT_IMP(a_busy_mid, out_valid && !last_byte, !in_ready)

	// A transaction in keeps the input closed in the next cycle
	`SVENC_ASSERT_NXT(a_in_close, in_valid && in_ready, !in_ready)

	// A stalled output byte holds
	`SVENC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(code_byte))

endmodule

bind signed_varint_encoder_top svenc_checker u_svenc_checker (.*);

`default_nettype wire
